>>> design/rrts_pkg.sv
package rrts_pkg;

	// Per-cycle commands broadcast to every cell
	typedef struct packed {
		logic load;        // write the addressed cell from the request
		logic upd;         // apply the tick decision to every ready cell
		logic pick_valid;  // a task was picked this tick
		logic pick_fin;    // the picked task completes this tick
	} ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_OUT
	} state_t;

	localparam int BURST_W = 12;
	localparam int ARR_W   = 16;
	localparam int SLOT_W  = 4;
	localparam int OUT_W   = 24;

endpackage

>>> design/rrts_if.sv
interface rrts_in_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [rrts_pkg::SLOT_W-1:0]  slot;
	logic [rrts_pkg::BURST_W-1:0] burst_length;
	logic [rrts_pkg::ARR_W-1:0]   arrival;

	modport source (output valid, operation, slot, burst_length, arrival, input ready);
	modport sink (input valid, operation, slot, burst_length, arrival, output ready);
endinterface

interface rrts_out_if;
	logic                       valid;
	logic                       ready;
	logic [rrts_pkg::OUT_W-1:0]  time_now;
	logic                       ran_valid;
	logic [rrts_pkg::SLOT_W-1:0] ran_slot;
	logic                       finished;
	logic [rrts_pkg::OUT_W-1:0]  finished_waiting;
	logic                       all_done;

	modport source (output valid, time_now, ran_valid, ran_slot, finished,
		finished_waiting, all_done, input ready);
	modport sink (input valid, time_now, ran_valid, ran_slot, finished,
		finished_waiting, all_done, output ready);
endinterface

>>> design/rrts_cell.sv
module rrts_cell #(
	parameter int IDX = 0,
	parameter int TW  = 24,
	parameter int IW  = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rrts_pkg::ctl_t               ctl,
	input  logic [TW-1:0]                now,
	input  logic [rrts_pkg::SLOT_W-1:0]  load_slot,
	input  logic [rrts_pkg::BURST_W-1:0] load_burst,
	input  logic [rrts_pkg::ARR_W-1:0]   load_arrival,
	input  logic [IW-1:0]                pick_slot,
	input  logic [TW-1:0]                fin_wait,
	input  logic                         tin_found,
	input  logic [IW-1:0]                tin_slot,
	input  logic [TW-1:0]                tin_wait,
	input  logic [rrts_pkg::BURST_W-1:0] tin_rem,
	input  logic [rrts_pkg::ARR_W:0]     tin_used,
	output logic                         tout_found,
	output logic [IW-1:0]                tout_slot,
	output logic [TW-1:0]                tout_wait,
	output logic [rrts_pkg::BURST_W-1:0] tout_rem,
	output logic [rrts_pkg::ARR_W:0]     tout_used,
	output logic                         has_work
);

	localparam int PW = TW + rrts_pkg::BURST_W;

	logic [rrts_pkg::ARR_W-1:0]   arr_q;
	logic [rrts_pkg::BURST_W-1:0] bur_q;
	logic [rrts_pkg::BURST_W-1:0] rem_q;
	logic [TW-1:0]                wait_q;
	logic                         found_q;
	logic [IW-1:0]                slot_q;
	logic [TW-1:0]                twait_q;
	logic [rrts_pkg::BURST_W-1:0] trem_q;
	logic [rrts_pkg::ARR_W:0]     tused_q;

	logic          ready;
	logic          take;
	logic [PW-1:0] prod_own;
	logic [PW-1:0] prod_tok;
	logic          is_load;
	logic          is_pick;

	// Ready: work left and already arrived
	assign ready    = (rem_q != '0) && (32'(arr_q) <= 32'(now));
	assign has_work = (rem_q != '0);

	// Cross-multiplied ratio compare against the incoming best
	assign prod_own = PW'(wait_q) * PW'(tin_rem);
	assign prod_tok = PW'(tin_wait) * PW'(rem_q);
	assign take     = ready && (!tin_found || (prod_own > prod_tok));

	assign is_load = ctl.load && (32'(load_slot) == IDX);
	assign is_pick = ctl.pick_valid && (32'(pick_slot) == IDX);

	// Pass the winner on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= tin_found | ready;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q  <= IW'(IDX);
			twait_q <= wait_q;
			trem_q  <= rem_q;
			tused_q <= (rrts_pkg::ARR_W+1)'(arr_q) + (rrts_pkg::ARR_W+1)'(bur_q);
		end else begin
			slot_q  <= tin_slot;
			twait_q <= tin_wait;
			trem_q  <= tin_rem;
			tused_q <= tin_used;
		end
	end

	assign tout_found = found_q;
	assign tout_slot  = slot_q;
	assign tout_wait  = twait_q;
	assign tout_rem   = trem_q;
	assign tout_used  = tused_q;

	// Task slot contents written by loads
	always_ff @(posedge clk) begin
		if (is_load) begin
			arr_q <= load_arrival;
			bur_q <= load_burst;
		end
	end

	// Remaining work and waited count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			wait_q <= '0;
		end else if (is_load) begin
			rem_q  <= load_burst;
			wait_q <= '0;
		end else if (ctl.upd && ready) begin
			if (is_pick) begin
				rem_q <= rem_q - 1'b1;
				if (ctl.pick_fin) begin
					wait_q <= fin_wait;
				end
			end else if (wait_q != {TW{1'b1}}) begin
				wait_q <= wait_q + 1'b1;
			end
		end
	end

endmodule

>>> design/response_ratio_tick_scheduler.sv
// Preemptive highest-response-ratio-next scheduler, one tick per request.
// sched_in carries requests: operation 0 loads a task slot (burst, arrival),
// operation 1 advances one time tick. Each request yields exactly one result
// on sched_out: tick time, slot that ran, completion flag with its waiting
// time, and whether any slot still has work.
// A row of MAX_TASKS cells holds the task table; on a tick the best candidate
// travels through the row one cell per cycle, each cell comparing its ratio
// by cross-multiplication, then every cell updates in parallel.
// A load goes from ST_IDLE straight to ST_OUT; a tick passes ST_SCAN while
// the candidate walks the cell row, then ST_UPD and ST_OUT. One request is
// in flight at a time.
// Reset clears remaining work, waited counts and the tick time; slot arrival
// and burst hold nothing until loaded.
// A result waits in the output register while the receiver stalls; the next
// request is accepted meanwhile, and its result waits until the register frees.
module response_ratio_tick_scheduler #(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	rrts_in_if.sink    sched_in,
	rrts_out_if.source sched_out
);

	localparam int N  = MAX_TASKS;
	localparam int TW = TIME_BITS;
	localparam int IW = (N > 1) ? $clog2(N) : 1;
	localparam int CW = $clog2(N + 1);
	localparam int UW = rrts_pkg::ARR_W + 1;

	rrts_pkg::state_t state_q, state_d;
	rrts_pkg::ctl_t   ctl;

	logic [TW-1:0] now_q;
	logic [CW-1:0] cnt_q;

	logic                         t_found [N+1];
	logic [IW-1:0]                t_slot  [N+1];
	logic [TW-1:0]                t_wait  [N+1];
	logic [rrts_pkg::BURST_W-1:0] t_rem   [N+1];
	logic [UW-1:0]                t_used  [N+1];
	logic [N-1:0]                 work;

	logic          accept;
	logic          out_free;
	logic [TW-1:0] done_t;
	logic [TW-1:0] fin_wait;
	logic          pick_fin;

	// Result held until the output register frees
	logic [TW-1:0]               r_time_q;
	logic                        r_ran_q;
	logic [rrts_pkg::SLOT_W-1:0] r_slot_q;
	logic                        r_fin_q;
	logic [TW-1:0]               r_wait_q;

	logic                        ov_q;
	logic [rrts_pkg::OUT_W-1:0]  o_time_q;
	logic                        o_ran_q;
	logic [rrts_pkg::SLOT_W-1:0] o_slot_q;
	logic                        o_fin_q;
	logic [rrts_pkg::OUT_W-1:0]  o_wait_q;
	logic                        o_done_q;

	assign sched_in.ready = (state_q == rrts_pkg::ST_IDLE);
	assign accept   = sched_in.valid && sched_in.ready;
	assign out_free = !ov_q || sched_out.ready;

	// Completion time and waiting of the picked task
	assign done_t   = (now_q == {TW{1'b1}}) ? now_q : now_q + 1'b1;
	assign pick_fin = t_found[N] && (t_rem[N] == rrts_pkg::BURST_W'(1));
	always_comb begin
		if (33'(done_t) > 33'(t_used[N])) begin
			fin_wait = TW'(33'(done_t) - 33'(t_used[N]));
		end else begin
			fin_wait = '0;
		end
	end

	// Next state and cell commands
	always_comb begin
		state_d        = state_q;
		ctl.load       = 1'b0;
		ctl.upd        = 1'b0;
		ctl.pick_valid = 1'b0;
		ctl.pick_fin   = 1'b0;
		unique case (state_q)
			rrts_pkg::ST_IDLE: begin
				if (accept) begin
					if (sched_in.operation) begin
						state_d = rrts_pkg::ST_SCAN;
					end else begin
						ctl.load = 1'b1;
						state_d  = rrts_pkg::ST_OUT;
					end
				end
			end
			rrts_pkg::ST_SCAN: begin
				if (cnt_q == CW'(N - 1)) begin
					state_d = rrts_pkg::ST_UPD;
				end
			end
			rrts_pkg::ST_UPD: begin
				ctl.upd        = 1'b1;
				ctl.pick_valid = t_found[N];
				ctl.pick_fin   = pick_fin;
				state_d        = rrts_pkg::ST_OUT;
			end
			rrts_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = rrts_pkg::ST_IDLE;
				end
			end
			default: state_d = rrts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::ST_IDLE;
			cnt_q   <= '0;
			now_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rrts_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == rrts_pkg::ST_UPD) begin
				now_q <= done_t;
			end
		end
	end

	// Capture result fields of a load or a tick
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_time_q <= now_q;
			r_ran_q  <= 1'b0;
			r_slot_q <= '0;
			r_fin_q  <= 1'b0;
			r_wait_q <= '0;
		end else if (ctl.upd) begin
			r_time_q <= now_q;
			r_ran_q  <= t_found[N];
			r_slot_q <= t_found[N] ? rrts_pkg::SLOT_W'(t_slot[N]) : '0;
			r_fin_q  <= pick_fin;
			r_wait_q <= pick_fin ? fin_wait : '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == rrts_pkg::ST_OUT && out_free) begin
			ov_q <= 1'b1;
		end else if (sched_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rrts_pkg::ST_OUT && out_free) begin
			o_time_q <= rrts_pkg::OUT_W'(r_time_q);
			o_ran_q  <= r_ran_q;
			o_slot_q <= r_slot_q;
			o_fin_q  <= r_fin_q;
			o_wait_q <= rrts_pkg::OUT_W'(r_wait_q);
			o_done_q <= (work == '0);
		end
	end

	assign sched_out.valid            = ov_q;
	assign sched_out.time_now         = o_time_q;
	assign sched_out.ran_valid        = o_ran_q;
	assign sched_out.ran_slot         = o_slot_q;
	assign sched_out.finished         = o_fin_q;
	assign sched_out.finished_waiting = o_wait_q;
	assign sched_out.all_done         = o_done_q;

	// Empty candidate enters the head of the row
	assign t_found[0] = 1'b0;
	assign t_slot[0]  = '0;
	assign t_wait[0]  = '0;
	assign t_rem[0]   = '0;
	assign t_used[0]  = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		rrts_cell #(
			.IDX (i),
			.TW  (TW),
			.IW  (IW)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.now          (now_q),
			.load_slot    (sched_in.slot),
			.load_burst   (sched_in.burst_length),
			.load_arrival (sched_in.arrival),
			.pick_slot    (t_slot[N]),
			.fin_wait     (fin_wait),
			.tin_found    (t_found[i]),
			.tin_slot     (t_slot[i]),
			.tin_wait     (t_wait[i]),
			.tin_rem      (t_rem[i]),
			.tin_used     (t_used[i]),
			.tout_found   (t_found[i+1]),
			.tout_slot    (t_slot[i+1]),
			.tout_wait    (t_wait[i+1]),
			.tout_rem     (t_rem[i+1]),
			.tout_used    (t_used[i+1]),
			.has_work     (work[i])
		);
	end

endmodule
